// ===== rtl/mrs_pkg.sv =====
// ----------------------------------------------------------------------------
// mrs_pkg: shared types, codes and pattern tables for the modem scanner
// Holds the item codes, response phases, the result layout and the three
// match patterns as constant lookup functions.
// ----------------------------------------------------------------------------
package mrs_pkg;

  localparam int unsigned BUFFER_SIZE_DEF = 1024;

  // Item kinds carried on the input tuser
  localparam logic [1:0] FUNC_BYTE     = 2'd0;
  localparam logic [1:0] FUNC_ARM_OK   = 2'd1;
  localparam logic [1:0] FUNC_ARM_RESP = 2'd2;

  // Response matcher phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_CAPTURE = 2'd2;

  localparam logic [2:0] OK_LEN   = 3'd4;
  localparam logic [2:0] HDR_LEN  = 3'd5;
  localparam logic [2:0] TERM_LEN = 3'd6;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_BIT     = 8'h20;

  // Result word, first field in the highest bits
  typedef struct packed {
    logic [9:0] capture_index;
    logic [7:0] capture_byte;
    logic       capture_valid;
    logic       response_done;
    logic [1:0] response_phase;
    logic       ok_searching;
    logic       ok_seen;
  } mrs_result_t;

  localparam int unsigned RESULT_W = $bits(mrs_result_t);

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c | CASE_BIT;
    end
    return r;
  endfunction

  // "ok\r\n"
  function automatic logic [7:0] ok_char(input logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0:    r = 8'h6f;
      3'd1:    r = 8'h6b;
      3'd2:    r = 8'h0d;
      3'd3:    r = 8'h0a;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // "+ipd,"
  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0:    r = 8'h2b;
      3'd1:    r = 8'h69;
      3'd2:    r = 8'h70;
      3'd3:    r = 8'h64;
      3'd4:    r = 8'h2c;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // "\n\rok\r\n"
  function automatic logic [7:0] term_char(input logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0:    r = 8'h0a;
      3'd1:    r = 8'h0d;
      3'd2:    r = 8'h6f;
      3'd3:    r = 8'h6b;
      3'd4:    r = 8'h0d;
      3'd5:    r = 8'h0a;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/mrs_scan_core.sv =====
// ----------------------------------------------------------------------------
// mrs_scan_core: matcher state and single-pass update
// Holds both matchers and the capture counter; computes the result of one
// item combinationally and commits the new state when enabled.
// ----------------------------------------------------------------------------
module mrs_scan_core #(
  parameter int unsigned BUFFER_SIZE = mrs_pkg::BUFFER_SIZE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [1:0]          func_i,
  input  logic [7:0]          rx_byte_i,
  output mrs_pkg::mrs_result_t result_o
);
  import mrs_pkg::*;

  localparam int unsigned CntW = $clog2(BUFFER_SIZE + 1);

  logic            ok_active_q, ok_active_d;
  logic [2:0]      ok_pos_q, ok_pos_d;
  logic            ok_found_q, ok_found_d;
  logic [1:0]      phase_q, phase_d;
  logic [2:0]      resp_pos_q, resp_pos_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;

  logic [7:0]      c;
  logic            ok_hit, hdr_hit, term_hit;
  logic [CntW+9:0] cnt_ext;

  assign c        = fold_lower(rx_byte_i);
  assign ok_hit   = (ok_pos_q < OK_LEN) && (ok_char(ok_pos_q) == c);
  assign hdr_hit  = (resp_pos_q < HDR_LEN) && (hdr_char(resp_pos_q) == c);
  assign term_hit = (resp_pos_q < TERM_LEN) && (term_char(resp_pos_q) == c);
  assign cnt_ext  = {10'd0, cnt_q};

  always_comb begin
    ok_active_d = ok_active_q;
    ok_pos_d    = ok_pos_q;
    ok_found_d  = ok_found_q;
    phase_d     = phase_q;
    resp_pos_d  = resp_pos_q;
    cnt_d       = cnt_q;
    done_d      = done_q;
    result_o.capture_valid = 1'b0;
    result_o.capture_byte  = 8'd0;
    result_o.capture_index = 10'd0;

    unique case (func_i)
      FUNC_ARM_OK: begin
        ok_pos_d    = 3'd0;
        ok_found_d  = 1'b0;
        ok_active_d = 1'b1;
      end
      FUNC_ARM_RESP: begin
        resp_pos_d = 3'd0;
        phase_d    = PH_HEADER;
        cnt_d      = '0;
        done_d     = 1'b0;
      end
      FUNC_BYTE: begin
        if (ok_active_q) begin
          ok_pos_d = ok_hit ? ok_pos_q + 3'd1 : 3'd0;
          if (ok_hit && (ok_pos_q == OK_LEN - 3'd1)) begin
            ok_found_d  = 1'b1;
            ok_active_d = 1'b0;
          end
        end
        case (phase_q)
          PH_HEADER: begin
            resp_pos_d = hdr_hit ? resp_pos_q + 3'd1 : 3'd0;
            if (hdr_hit && (resp_pos_q == HDR_LEN - 3'd1)) begin
              phase_d    = PH_CAPTURE;
              resp_pos_d = 3'd0;
            end
          end
          PH_CAPTURE: begin
            if (cnt_q < CntW'(BUFFER_SIZE)) begin
              result_o.capture_valid = 1'b1;
              result_o.capture_byte  = c;
              result_o.capture_index = cnt_ext[9:0];
              cnt_d = cnt_q + CntW'(1);
            end
            resp_pos_d = term_hit ? resp_pos_q + 3'd1 : 3'd0;
            if (term_hit && (resp_pos_q == TERM_LEN - 3'd1)) begin
              done_d  = 1'b1;
              phase_d = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    result_o.ok_seen        = ok_found_d;
    result_o.ok_searching   = ok_active_d;
    result_o.response_phase = phase_d;
    result_o.response_done  = done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_active_q <= 1'b0;
      ok_pos_q    <= 3'd0;
      ok_found_q  <= 1'b0;
      phase_q     <= PH_IDLE;
      resp_pos_q  <= 3'd0;
      cnt_q       <= '0;
      done_q      <= 1'b0;
    end else if (en_i) begin
      ok_active_q <= ok_active_d;
      ok_pos_q    <= ok_pos_d;
      ok_found_q  <= ok_found_d;
      phase_q     <= phase_d;
      resp_pos_q  <= resp_pos_d;
      cnt_q       <= cnt_d;
      done_q      <= done_d;
    end
  end

endmodule

// ===== rtl/modem_response_scanner.sv =====
// ----------------------------------------------------------------------------
// modem_response_scanner: streaming scanner for modem replies
// Input request register, single-pass match logic, result register.
// ----------------------------------------------------------------------------
// Each input request is either a received byte (tuser = 0), an arm of the
// completion search (tuser = 1) or an arm of the server response search
// (tuser = 2); code 3 changes nothing but still yields a result. Bytes are
// folded to lower case before matching. Every request yields exactly one
// result word carrying the status after the update plus, while the payload
// after "+ipd," is being captured, the byte and its buffer index. The block
// sustains one request per clock while the output is not stalled: a request is
// held in the input register, the matcher update runs while it is held there,
// and the result lands in the output register; back-pressure on the output
// stalls the input only when both registers are full.
module modem_response_scanner #(
  parameter int unsigned BUFFER_SIZE = mrs_pkg::BUFFER_SIZE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
  input  logic [1:0]                    s_axis_tuser,  // [1:0] func
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] ok_seen, [1] ok_searching, [3:2] response_phase, [4] response_done,
  // [5] capture_valid, [13:6] capture_byte, [23:14] capture_index
  output logic [mrs_pkg::RESULT_W-1:0]  m_axis_tdata
);
  import mrs_pkg::*;

  logic        in_valid_q;
  logic [1:0]  func_q;
  logic [7:0]  byte_q;
  logic        out_valid_q;
  mrs_result_t result_d, result_q;
  logic        advance;
  logic        in_take;

  // Move the held request into the result register when it has room
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  mrs_scan_core #(
    .BUFFER_SIZE(BUFFER_SIZE)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .func_i   (func_q),
    .rx_byte_i(byte_q),
    .result_o (result_d)
  );

  // Input request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q <= s_axis_tuser;
      byte_q <= s_axis_tdata;
    end
  end

  // Result register: hold while the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = result_q;

endmodule

// ===== rtl/mrs_checker.sv =====
// ----------------------------------------------------------------------------
// mrs_checker: port-level checks for the modem response scanner
// Watches the result stream and flags inconsistent status words.
// ----------------------------------------------------------------------------
module mrs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [mrs_pkg::RESULT_W-1:0] m_axis_tdata
);
  import mrs_pkg::*;

  mrs_result_t r;
  assign r = m_axis_tdata;

  // Stalled result must hold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Completion found and still searching are exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(r.ok_seen && r.ok_searching))
    else $error("ok matcher both found and searching");

  // Done only once the response matcher has gone idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r.response_done |-> r.response_phase == PH_IDLE)
    else $error("response done while still active");

  // No capture while seeking the header; idle capture fields are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (r.capture_valid ? (r.response_phase != PH_HEADER)
                       : (r.capture_byte == 8'd0 && r.capture_index == 10'd0)))
    else $error("capture fields inconsistent");

endmodule

bind modem_response_scanner mrs_checker u_mrs_checker (.*);
